### sv/twps_pkg.sv
// shared types and constants for the textured wall pixel shader
// no dependencies; imported by every module of the block
package twps_pkg;

    // texture and screen geometry
    localparam int TEX_W    = 64;
    localparam int TEX_H    = 64;
    localparam int SCREEN_H = 480;
    localparam int TW_LOG2  = $clog2(TEX_W);
    localparam int TH_LOG2  = $clog2(TEX_H);

    // texture row width and fixed-point fraction of the row mapping
    localparam int TY_W     = TH_LOG2;
    localparam int FRAC_W   = 8;

    // row mapping arithmetic: signed offset, numerator and divisor
    localparam int C_W      = 26;
    localparam int MAG_W    = C_W - 1;
    localparam int N_W      = MAG_W + TH_LOG2;
    localparam int D_W      = 16 + FRAC_W;

    // quotient steps: one saturation check plus one per texture row bit
    localparam int NSTEP    = TY_W + 1;

    // colour constants
    localparam logic [23:0] DARK_MASK  = 24'h7F7F7F;
    localparam logic [7:0]  RED_CROSS  = 8'd254;
    localparam logic [7:0]  RED_BRICK  = 8'd192;
    localparam logic [7:0]  FLAT_GREY  = 8'd128;
    localparam int          BRICK_SIZE = 16;

    typedef struct packed {
        logic [9:0]  column;
        logic [8:0]  row;
        logic [15:0] line_height;
        logic        wall_side;
        logic [2:0]  texture_index;
        logic [5:0]  tex_col;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [8:0]  out_row;
        logic [23:0] pixel_color;
    } t_out_item;

    // pixel data that rides along the divider stages
    typedef struct packed {
        logic [9:0]  column;
        logic [8:0]  row;
        logic        wall_side;
        logic [2:0]  texture_index;
        logic [5:0]  tex_col;
    } t_meta;

endpackage

### sv/textured_wall_pixel_shader_core.sv
// top level of the textured wall pixel shader: row mapping, divider pipeline, texel stage
// depends on twps_pkg and twps_div_stage
//
// Takes one wall pixel per clock and returns its RGB888 colour with the screen column and
// row. The texture row is floor(c * TEX_H / (256 * line_height)) with
// c = row*256 - SCREEN_H*128 + line_height*128, clamped to 0..TEX_H-1; a zero line
// height counts as one. Throughput is one item per clock with no gaps while the output
// side does not stall. One stage forms the numerator and divisor, seven stages each
// resolve one quotient step of the restoring divider (a saturation check and then one
// texture row bit per stage), and the last stage evaluates the procedural texture and
// the side darkening. Every stage holds its item while the stage after it is full, so
// stalls on the output side back up through the pipe and bubbles are squeezed out.
module textured_wall_pixel_shader_core
    import twps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // texture numbers
    typedef enum logic [2:0] {
        TEX_CROSS     = 3'd0,
        TEX_GREY_GRAD = 3'd1,
        TEX_RG_GRAD   = 3'd2,
        TEX_GREY_XOR  = 3'd3,
        TEX_GREEN_XOR = 3'd4,
        TEX_BRICK     = 3'd5,
        TEX_RED_RAMP  = 3'd6,
        TEX_FLAT      = 3'd7
    } t_tex;

    // procedural texel colour at texture column x, row y
    function automatic logic [23:0] f_texel(input logic [2:0] tex,
                                            input logic [5:0] x,
                                            input logic [TY_W-1:0] y);
        logic [15:0] xw;
        logic [15:0] yw;
        logic [7:0]  xy;
        logic [7:0]  yc;
        logic [7:0]  xr;
        logic [23:0] col;
        xw = 16'(x);
        yw = 16'(y);
        xy = 8'(((yw * 16'd128) >> TH_LOG2) + ((xw * 16'd128) >> TW_LOG2));
        yc = 8'((yw * 16'd256) >> TH_LOG2);
        xr = 8'((xw * 16'd256) >> TW_LOG2) ^ yc;
        case (t_tex'(tex))
            TEX_CROSS: begin
                // black diagonals
                col = ((xw != yw) && (xw != 16'(TEX_W) - yw)) ? {RED_CROSS, 16'd0} : 24'd0;
            end
            TEX_GREY_GRAD: col = {xy, xy, xy};
            TEX_RG_GRAD:   col = {xy, xy, 8'd0};
            TEX_GREY_XOR:  col = {xr, xr, xr};
            TEX_GREEN_XOR: col = {8'd0, xr, 8'd0};
            TEX_BRICK: begin
                // black mortar lines on the brick grid
                col = ((xw % 16'(BRICK_SIZE)) != 16'd0 && (yw % 16'(BRICK_SIZE)) != 16'd0)
                    ? {RED_BRICK, 16'd0} : 24'd0;
            end
            TEX_RED_RAMP:  col = {yc, 16'd0};
            TEX_FLAT:      col = {FLAT_GREY, FLAT_GREY, FLAT_GREY};
            default:       col = {FLAT_GREY, FLAT_GREY, FLAT_GREY};
        endcase
        return col;
    endfunction

    // pipeline position 0 is the set-up stage, positions 1..NSTEP the divider steps
    logic             w_vld  [0:NSTEP];
    logic [N_W-1:0]   w_rem  [0:NSTEP];
    logic [D_W-1:0]   w_d    [0:NSTEP];
    logic [TY_W:0]    w_q    [0:NSTEP];
    t_meta            w_meta [0:NSTEP];
    logic             w_adv  [0:NSTEP+1];

    // ---------------- set-up stage: numerator and divisor ----------------
    logic             r_s1_vld;
    logic [N_W-1:0]   r_s1_num;
    logic [D_W-1:0]   r_s1_den;
    t_meta            r_s1_meta;

    logic [15:0]      w_lh;
    logic [C_W-1:0]   w_c;
    logic [N_W-1:0]   n_s1_num;
    t_meta            n_s1_meta;

    always_comb begin
        // zero height behaves as height one
        w_lh = (i_in_data.line_height == 16'd0) ? 16'd1 : i_in_data.line_height;
        // c = row*256 - SCREEN_H*128 + lh*128, two's complement
        w_c  = C_W'({i_in_data.row, 8'd0}) + C_W'({w_lh, 7'd0}) - C_W'(SCREEN_H * 128);
        // rows above the slice map to zero, so a negative offset divides as zero
        n_s1_num = w_c[C_W-1] ? '0 : (N_W'(w_c[MAG_W-1:0]) << TH_LOG2);

        n_s1_meta.column        = i_in_data.column;
        n_s1_meta.row           = i_in_data.row;
        n_s1_meta.wall_side     = i_in_data.wall_side;
        n_s1_meta.texture_index = i_in_data.texture_index;
        // texture column saturates at the right edge
        n_s1_meta.tex_col       = (16'(i_in_data.tex_col) > 16'(TEX_W - 1))
                                ? 6'(TEX_W - 1) : i_in_data.tex_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv[0]) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_in_valid) begin
            r_s1_num  <= n_s1_num;
            r_s1_den  <= {w_lh, {FRAC_W{1'b0}}};
            r_s1_meta <= n_s1_meta;
        end
    end

    assign w_vld[0]  = r_s1_vld;
    assign w_rem[0]  = r_s1_num;
    assign w_d[0]    = r_s1_den;
    assign w_q[0]    = '0;
    assign w_meta[0] = r_s1_meta;

    // ---------------- stall chain ----------------
    // a stage may load when it is empty or the stage after it loads
    logic r_out_vld;
    t_out_item r_out_data;

    assign w_adv[NSTEP+1] = ~r_out_vld | i_out_ready;

    for (genvar p = 0; p <= NSTEP; p++) begin : g_adv
        assign w_adv[p] = ~w_vld[p] | w_adv[p+1];
    end

    assign o_in_ready = w_adv[0];

    // ---------------- divider steps ----------------
    // first step tests against TEX_H (saturation), then one texture row bit per step
    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        twps_div_stage #(
            .SHIFT (TY_W - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv[k+1]),
            .i_vld   (w_vld[k]),
            .i_rem   (w_rem[k]),
            .i_d     (w_d[k]),
            .i_q     (w_q[k]),
            .i_meta  (w_meta[k]),
            .o_vld   (w_vld[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_d     (w_d[k+1]),
            .o_q     (w_q[k+1]),
            .o_meta  (w_meta[k+1])
        );
    end

    // ---------------- texel stage and output register ----------------
    logic [TY_W-1:0] w_ty;
    logic [23:0]     w_color;
    t_out_item       n_out_data;

    always_comb begin
        // clamp at the bottom texture row when the quotient reached TEX_H
        w_ty    = w_q[NSTEP][TY_W] ? TY_W'(TEX_H - 1) : w_q[NSTEP][TY_W-1:0];
        w_color = f_texel(w_meta[NSTEP].texture_index, w_meta[NSTEP].tex_col, w_ty);
        // y-side hits are drawn at half brightness
        if (w_meta[NSTEP].wall_side) begin
            w_color = (w_color >> 1) & DARK_MASK;
        end
        n_out_data.out_column  = w_meta[NSTEP].column;
        n_out_data.out_row     = w_meta[NSTEP].row;
        n_out_data.pixel_color = w_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv[NSTEP+1]) begin
            r_out_vld <= w_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NSTEP+1] && w_vld[NSTEP]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // ---------------- checks ----------------
    // input side only backs up when the whole pipe is full behind a stalled result
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && w_vld[NSTEP]))
        else $error("input blocked while pipe has room");

    // an accepted item lands in the set-up stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_vld[0])
        else $error("accepted item lost at set-up stage");

    // the last divider step keeps its item while the output register is blocked
    a_last_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[NSTEP] && !w_adv[NSTEP]) |=> (w_vld[NSTEP] && $stable(w_q[NSTEP])))
        else $error("divider item dropped during stall");

endmodule

### sv/twps_div_stage.sv
// one registered compare-subtract step of the texture row divider
// depends on twps_pkg
module twps_div_stage
    import twps_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [N_W-1:0]   i_rem,
    input  logic [D_W-1:0]   i_d,
    input  logic [TY_W:0]    i_q,
    input  t_meta            i_meta,
    output logic             o_vld,
    output logic [N_W-1:0]   o_rem,
    output logic [D_W-1:0]   o_d,
    output logic [TY_W:0]    o_q,
    output t_meta            o_meta
);

    logic             r_vld;
    logic [N_W-1:0]   r_rem;
    logic [D_W-1:0]   r_d;
    logic [TY_W:0]    r_q;
    t_meta            r_meta;

    logic [N_W-1:0]   w_sub;
    logic [N_W:0]     w_trial;
    logic             w_take;
    logic [N_W-1:0]   n_rem;
    logic [TY_W:0]    n_q;

    always_comb begin
        w_sub        = N_W'(i_d) << SHIFT;
        w_trial      = {1'b0, i_rem} - {1'b0, w_sub};
        w_take       = ~w_trial[N_W];
        n_rem        = w_take ? w_trial[N_W-1:0] : i_rem;
        n_q          = i_q;
        n_q[SHIFT]   = w_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_vld) begin
            r_rem  <= n_rem;
            r_d    <= i_d;
            r_q    <= n_q;
            r_meta <= i_meta;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_d    = r_d;
    assign o_q    = r_q;
    assign o_meta = r_meta;

endmodule

### tb/sv/tb.sv
// self-checking testbench for textured_wall_pixel_shader_core
// depends on twps_pkg for the item structs and the texture and screen geometry
module tb
    import twps_pkg::*;
();

    // texture numbers as the block decodes them
    typedef enum logic [2:0] {
        TEX_CROSS      = 3'd0,
        TEX_GREY_SUM   = 3'd1,
        TEX_YELLOW_SUM = 3'd2,
        TEX_GREY_XOR   = 3'd3,
        TEX_GREEN_XOR  = 3'd4,
        TEX_BRICK      = 3'd5,
        TEX_RED_RAMP   = 3'd6,
        TEX_FLAT       = 3'd7
    } t_texture;

    // receiver behavior, picked anew at random for each stretch of cycles
    typedef enum logic [1:0] {
        READY_ALWAYS   = 2'd0,
        READY_MOSTLY   = 2'd1,
        READY_SELDOM   = 2'd2,
        READY_PERIODIC = 2'd3
    } t_ready_mode;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int SETTLE_WAIT  = 24;    // wait well past the depth of the pipe
    localparam int PRINT_CAP    = 40;    // mismatch lines printed before going quiet

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // requests waiting for the driver and pixels the block still owes us
    t_in_item  requests_to_send[$];
    t_out_item pixels_due[$];
    int        drain_points[$];   // request counts at which the sender waits for the pipe to empty

    int          total_requests = 0;
    int          sent_count = 0;
    int          taken_count = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          mode_left = 0;
    t_ready_mode ready_mode = READY_ALWAYS;

    textured_wall_pixel_shader_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // pixel predictor
    // ------------------------------------------------------------------

    // screen row to texture row: signed fixed-point offset into the slice,
    // scaled by texture height and divided by the slice height, both
    // divisions truncating toward zero, then clamped into the texture
    function automatic int texture_row(input logic [8:0] row, input logic [15:0] height);
        longint slice_h;
        longint offset;
        longint tex_y;
        slice_h = (height == 16'd0) ? 64'sd1 : longint'(height);  // zero height counts as one
        offset  = longint'(row) * 256 - longint'(SCREEN_H) * 128 + slice_h * 128;
        tex_y   = ((offset * TEX_H) / slice_h) / 256;
        if (tex_y < 0)
            tex_y = 0;
        if (tex_y > TEX_H - 1)
            tex_y = TEX_H - 1;
        return int'(tex_y);
    endfunction

    // procedural texel, red in the top byte
    function automatic logic [23:0] shade_texel(input logic [2:0] tex, input int x, input int y);
        int          ramp_sum;
        int          ramp_y;
        int          xor_mix;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        ramp_sum = y * 128 / TEX_H + x * 128 / TEX_W;
        ramp_y   = y * 256 / TEX_H;
        xor_mix  = ((x * 256 / TEX_W) ^ (y * 256 / TEX_H)) & 255;
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
        case (t_texture'(tex))
            TEX_CROSS: begin
                // black on both diagonals
                if (x != y && x != TEX_W - y)
                    red = 8'd254;
            end
            TEX_GREY_SUM: begin
                red   = ramp_sum[7:0];
                green = ramp_sum[7:0];
                blue  = ramp_sum[7:0];
            end
            TEX_YELLOW_SUM: begin
                red   = ramp_sum[7:0];
                green = ramp_sum[7:0];
            end
            TEX_GREY_XOR: begin
                red   = xor_mix[7:0];
                green = xor_mix[7:0];
                blue  = xor_mix[7:0];
            end
            TEX_GREEN_XOR: begin
                green = xor_mix[7:0];
            end
            TEX_BRICK: begin
                // mortar lines every 16 texels in both directions
                if (x % 16 != 0 && y % 16 != 0)
                    red = 8'd192;
            end
            TEX_RED_RAMP: begin
                red = ramp_y[7:0];
            end
            default: begin
                red   = 8'd128;
                green = 8'd128;
                blue  = 8'd128;
            end
        endcase
        return {red, green, blue};
    endfunction

    function automatic t_out_item predict_pixel(input t_in_item req);
        t_out_item   pix;
        int          x;
        logic [23:0] color;
        x = (int'(req.tex_col) > TEX_W - 1) ? TEX_W - 1 : int'(req.tex_col);
        color = shade_texel(req.texture_index, x, texture_row(req.row, req.line_height));
        if (req.wall_side)
            color = (color >> 1) & 24'h7F7F7F;  // y-side walls at half brightness
        pix.out_column  = req.column;
        pix.out_row     = req.row;
        pix.pixel_color = color;
        return pix;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic t_in_item make_request(input int column, input int row, input int height,
                                              input bit side, input t_texture tex, input int tx);
        t_in_item req;
        req.column        = column[9:0];
        req.row           = row[8:0];
        req.line_height   = height[15:0];
        req.wall_side     = side;
        req.texture_index = tex;
        req.tex_col       = tx[5:0];
        return req;
    endfunction

    // most items fall on the visible part of a slice of random height, so
    // the texture row sweeps its whole range; the rest is unconstrained noise
    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned bits;
        int unsigned half;
        int unsigned low_row;
        int unsigned high_row;
        int unsigned flavor;
        int          tex_y;
        flavor = $urandom_range(0, 99);
        req.column = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(640, 1023))
                                                 : 10'($urandom_range(0, 639));
        req.wall_side     = 1'($urandom_range(0, 1));
        req.texture_index = 3'($urandom_range(0, 7));
        if (flavor < 75) begin
            // slice heights spread over every magnitude up to the full 16 bits
            bits = $urandom_range(1, 16);
            req.line_height = 16'($urandom_range(1 << (bits - 1), (1 << bits) - 1));
            half     = req.line_height / 2;
            low_row  = (half >= 240) ? 0 : 240 - half;
            high_row = (240 + half > 479) ? 479 : 240 + half;
            req.row  = 9'($urandom_range(low_row, high_row));
        end else begin
            req.line_height = (flavor < 78) ? 16'd0 : 16'($urandom_range(0, 65535));
            req.row = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(480, 511))
                                                  : 9'($urandom_range(0, 479));
        end
        // steer some texture columns onto the diagonals of the cross
        tex_y = texture_row(req.row, req.line_height);
        case ($urandom_range(0, 7))
            0:       req.tex_col = 6'(tex_y);
            1:       req.tex_col = 6'(TEX_W - tex_y);
            default: req.tex_col = 6'($urandom_range(0, 63));
        endcase
        return req;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // ------------------------------------------------------------------
    // driver: one request per handshake, bursts with random gaps between
    // them, and a full drain of the pipe at each drain point
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        t_in_item next_req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && sent_count != taken_count) begin
            // current item not yet taken, keep it on the bus
        end else if (requests_to_send.size() == 0) begin
            in_valid <= 1'b0;
        end else if (drain_points.size() != 0 && sent_count == drain_points[0]) begin
            in_valid <= 1'b0;
            if (pixels_due.size() == 0)
                void'(drain_points.pop_front());
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else begin
            next_req = requests_to_send.pop_front();
            in_item    <= next_req;
            in_valid   <= 1'b1;
            sent_count <= sent_count + 1;
            if (burst_left <= 1) begin
                // now and then a long burst with no gaps at all
                burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(1, 20);
                gap_left   <= $urandom_range(0, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure: a mode held for a random stretch of cycles
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= t_ready_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                READY_ALWAYS:   out_ready <= 1'b1;
                READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
                READY_SELDOM:   out_ready <= ($urandom_range(0, 3) == 0);
                default:        out_ready <= (mode_left % 5 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every accepted request, compare every accepted
    // pixel against the oldest prediction, track cycles with no progress
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                pixels_due.push_back(predict_pixel(in_item));
                taken_count <= taken_count + 1;
            end
            if (out_valid && out_ready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("unexpected pixel, column", out_item.out_column, 0);
                end else begin
                    want = pixels_due.pop_front();
                    if (out_item.out_column !== want.out_column)
                        report_mismatch("out_column", out_item.out_column, want.out_column);
                    if (out_item.out_row !== want.out_row)
                        report_mismatch("out_row", out_item.out_row, want.out_row);
                    if (out_item.pixel_color !== want.pixel_color)
                        report_mismatch("pixel_color", out_item.pixel_color, want.pixel_color);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: the run is stuck once neither side has moved for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        // clamping at both ends, zero slice height and field extremes
        requests_to_send.push_back(make_request(0, 0, 1, 1'b0, TEX_CROSS, 0));
        requests_to_send.push_back(make_request(639, 479, 1, 1'b1, TEX_CROSS, 63));
        requests_to_send.push_back(make_request(1023, 511, 65535, 1'b0, TEX_GREY_SUM, 63));
        requests_to_send.push_back(make_request(0, 0, 0, 1'b1, TEX_GREY_SUM, 0));
        requests_to_send.push_back(make_request(512, 256, 0, 1'b0, TEX_FLAT, 42));
        // with a 64 pixel slice, texture row y sits on screen row 208 + y
        requests_to_send.push_back(make_request(100, 228, 64, 1'b0, TEX_CROSS, 20));
        requests_to_send.push_back(make_request(101, 248, 64, 1'b1, TEX_CROSS, 24));
        requests_to_send.push_back(make_request(102, 208, 64, 1'b0, TEX_CROSS, 0));
        // every texture but the cross at one texel, alternating the wall side
        requests_to_send.push_back(make_request(200, 245, 64, 1'b0, TEX_GREY_SUM, 45));
        requests_to_send.push_back(make_request(201, 245, 64, 1'b1, TEX_YELLOW_SUM, 45));
        requests_to_send.push_back(make_request(202, 245, 64, 1'b0, TEX_GREY_XOR, 45));
        requests_to_send.push_back(make_request(203, 245, 64, 1'b1, TEX_GREEN_XOR, 45));
        requests_to_send.push_back(make_request(204, 245, 64, 1'b0, TEX_BRICK, 45));
        requests_to_send.push_back(make_request(205, 245, 64, 1'b1, TEX_RED_RAMP, 45));
        requests_to_send.push_back(make_request(206, 245, 64, 1'b0, TEX_FLAT, 45));
        // brick mortar on a column line, on a row line, and plain brick
        requests_to_send.push_back(make_request(300, 241, 64, 1'b0, TEX_BRICK, 16));
        requests_to_send.push_back(make_request(301, 240, 64, 1'b1, TEX_BRICK, 5));
        requests_to_send.push_back(make_request(302, 217, 64, 1'b0, TEX_BRICK, 7));
        // gradient and pattern extremes
        requests_to_send.push_back(make_request(400, 271, 64, 1'b1, TEX_GREY_SUM, 63));
        requests_to_send.push_back(make_request(401, 208, 64, 1'b0, TEX_GREY_XOR, 63));
        requests_to_send.push_back(make_request(402, 271, 64, 1'b1, TEX_GREEN_XOR, 0));
        requests_to_send.push_back(make_request(403, 271, 64, 1'b0, TEX_RED_RAMP, 0));
        // tallest slice and a slice exactly one screen high
        requests_to_send.push_back(make_request(500, 0, 65535, 1'b0, TEX_RED_RAMP, 31));
        requests_to_send.push_back(make_request(501, 0, 480, 1'b1, TEX_GREY_SUM, 10));
        requests_to_send.push_back(make_request(502, 479, 480, 1'b0, TEX_GREY_SUM, 10));

        // let the pipe empty after the directed part and twice during the random part
        drain_points.push_back(requests_to_send.size());
        drain_points.push_back(requests_to_send.size() + 400);
        drain_points.push_back(requests_to_send.size() + 900);

        repeat (RANDOM_ITEMS)
            requests_to_send.push_back(random_request());
        total_requests = requests_to_send.size();

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (taken_count != total_requests || pixels_due.size() != 0)
            @(posedge clk);
        // any stray pixel after the last one would show up here
        repeat (SETTLE_WAIT)
            @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
